// ===== hdl/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types and constants of the zero-run visibility row decoder.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = BYTE_W * WORD_BYTES;
  localparam int FILL_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int CFG_W       = 14;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic {
    CMD_LIT = 1'b0,
    CMD_RUN = 1'b1
  } cmd_kind_t;

  // one classified command: a literal byte or a zero run of value bytes
  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  value;
  } cmd_t;

endpackage

// ===== hdl/pvs_byte_if.sv =====
// ----------------------------------------------------------------------------
// pvs_byte_if
// Valid/ready channel carrying one compressed byte per transaction.
// ----------------------------------------------------------------------------
interface pvs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;

  modport source (output valid, output compressed_byte, input ready);
  modport sink   (input valid, input compressed_byte, output ready);
endinterface

// ===== hdl/pvs_word_if.sv =====
// ----------------------------------------------------------------------------
// pvs_word_if
// Valid/ready channel carrying one packed decoded word per transaction.
// ----------------------------------------------------------------------------
interface pvs_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_word;
  logic [3:0]  byte_count;
  logic        row_end;

  modport source (output valid, output decoded_word, output byte_count, output row_end,
                  input ready);
  modport sink   (input valid, input decoded_word, input byte_count, input row_end,
                  output ready);
endinterface

// ===== hdl/pvs_zero_run_decoder.sv =====
// ----------------------------------------------------------------------------
// pvs_zero_run_decoder
// Zero-run visibility row decoder with 64-bit packed output.
// ----------------------------------------------------------------------------
// The front accepts one compressed byte per cycle while its four-entry command
// queue has room; tokens and zero counts make no command. The back retires one
// command step per cycle: a literal places one byte, and a zero run places up to
// eight zeros per step (bounded by the free bytes of the current word and by the
// row end). Each cycle of the back needs the output register free or being taken.
// Throughput is set by the back packing step and the output handshake. Writing
// cluster_count drops any partly decoded row and resets the decoder; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module pvs_zero_run_decoder #(
  parameter int MAX_CLUSTERS = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pvs_pkg::CFG_W-1:0]     cfg_wdata,
  pvs_byte_if.sink                      in_ch,
  pvs_word_if.source                    out_ch
);

  localparam int ROW_W = $clog2(MAX_CLUSTERS / 8 + 1);

  logic [ROW_W-1:0]   row_len_r;
  logic [ROW_W-1:0]   row_len_nxt;
  logic [31:0]        clusters;

  logic               q_push;
  pvs_pkg::cmd_t      q_data;
  logic               q_full;
  logic               q_not_empty;
  pvs_pkg::cmd_t      q_head;
  logic               q_pop;

  // zero clusters count as one, large counts saturate
  always_comb begin
    clusters = 32'(cfg_wdata);
    if (clusters == 32'd0) begin
      clusters = 32'd1;
    end
    if (clusters > 32'(MAX_CLUSTERS)) begin
      clusters = 32'(MAX_CLUSTERS);
    end
    row_len_nxt = ROW_W'((clusters + 32'd7) >> 3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= ROW_W'(1);
    end else if (cfg_we) begin
      row_len_r <= row_len_nxt;
    end
  end

  pvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (cfg_we),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.compressed_byte),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  pvs_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (cfg_we),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pvs_back #(
    .ROW_W (ROW_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .flush       (cfg_we),
    .row_len     (row_len_r),
    .cmd_valid   (q_not_empty),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_word    (out_ch.decoded_word),
    .out_count   (out_ch.byte_count),
    .out_row_end (out_ch.row_end)
  );

endmodule

// ===== hdl/pvs_front.sv =====
// ----------------------------------------------------------------------------
// pvs_front
// Accepts compressed bytes and classifies them into literal and run commands.
// ----------------------------------------------------------------------------
module pvs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            flush,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            q_full,
  output logic            q_push,
  output pvs_pkg::cmd_t   q_data
);

  logic expect_r;
  logic expect_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    expect_nxt   = expect_r;
    q_push       = 1'b0;
    q_data.kind  = pvs_pkg::CMD_LIT;
    q_data.value = in_byte;
    if (accept) begin
      if (expect_r) begin
        // run count; a zero count just ends the token
        expect_nxt  = 1'b0;
        q_data.kind = pvs_pkg::CMD_RUN;
        q_push      = (in_byte != 8'd0);
      end else if (in_byte == 8'd0) begin
        expect_nxt = 1'b1;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      expect_r <= 1'b0;
    end else begin
      expect_r <= expect_nxt;
    end
  end

endmodule

// ===== hdl/pvs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pvs_cmd_fifo
// Short command queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module pvs_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            flush,
  input  logic            push,
  input  pvs_pkg::cmd_t   push_data,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output pvs_pkg::cmd_t   head
);

  pvs_pkg::cmd_t                  slot_r [pvs_pkg::QUEUE_DEPTH];
  logic [pvs_pkg::QUEUE_AW-1:0]   wr_ptr_r;
  logic [pvs_pkg::QUEUE_AW-1:0]   rd_ptr_r;
  logic [pvs_pkg::QUEUE_AW:0]     count_r;
  logic                           do_push;
  logic                           do_pop;

  assign full      = (count_r == (pvs_pkg::QUEUE_AW+1)'(pvs_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/pvs_back.sv =====
// ----------------------------------------------------------------------------
// pvs_back
// Expands commands into decoded bytes, packs them into words and ends rows.
// ----------------------------------------------------------------------------
module pvs_back #(
  parameter int ROW_W = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               flush,
  input  logic [ROW_W-1:0]   row_len,
  input  logic               cmd_valid,
  input  pvs_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_word,
  output logic [3:0]         out_count,
  output logic               out_row_end
);

  localparam int CW = (ROW_W > pvs_pkg::BYTE_W) ? ROW_W : pvs_pkg::BYTE_W;

  logic [pvs_pkg::FILL_W-1:0]   fill_r;
  logic [55:0]                  buf_r;
  logic [ROW_W-1:0]             row_pos_r;
  logic [pvs_pkg::BYTE_W-1:0]   run_done_r;
  logic                         out_valid_r;
  logic [63:0]                  out_word_r;
  logic [3:0]                   out_count_r;
  logic                         out_row_end_r;

  logic                         go;
  logic [pvs_pkg::BYTE_W-1:0]   run_rem;
  logic [ROW_W-1:0]             row_left;
  logic [3:0]                   room;
  logic [3:0]                   step;
  logic [3:0]                   new_fill;
  logic [ROW_W-1:0]             new_pos;
  logic                         done;
  logic                         emit;
  logic [63:0]                  word;

  assign go       = cmd_valid && (!out_valid_r || out_ready);
  assign run_rem  = cmd.value - run_done_r;
  assign row_left = row_len - row_pos_r;
  assign room     = 4'(pvs_pkg::WORD_BYTES) - {1'b0, fill_r};

  // bytes placed this cycle: one literal, or as many zeros as fit
  always_comb begin
    step = 4'd1;
    if (cmd.kind == pvs_pkg::CMD_RUN) begin
      step = room;
      if (CW'(run_rem) < CW'(step)) begin
        step = 4'(run_rem);
      end
      if (CW'(row_left) < CW'(step)) begin
        step = 4'(row_left);
      end
    end
  end

  assign new_fill = {1'b0, fill_r} + step;
  assign new_pos  = row_pos_r + ROW_W'(step);
  assign done     = (new_pos == row_len);
  assign emit     = (new_fill == 4'(pvs_pkg::WORD_BYTES)) || done;

  always_comb begin
    word = {8'd0, buf_r};
    if (cmd.kind == pvs_pkg::CMD_LIT) begin
      word = word | (64'(cmd.value) << {fill_r, 3'b000});
    end
  end

  always_comb begin
    cmd_pop = 1'b0;
    if (go) begin
      // a run cut at the row end drops what is left of it
      cmd_pop = (cmd.kind == pvs_pkg::CMD_LIT) || done || (8'(step) == run_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      fill_r      <= '0;
      buf_r       <= '0;
      row_pos_r   <= '0;
      run_done_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go) begin
        run_done_r <= cmd_pop ? '0 : run_done_r + 8'(step);
        if (emit) begin
          fill_r      <= '0;
          buf_r       <= '0;
          row_pos_r   <= done ? '0 : new_pos;
        end else begin
          fill_r    <= new_fill[pvs_pkg::FILL_W-1:0];
          buf_r     <= word[55:0];
          row_pos_r <= new_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_word_r    <= word;
      out_count_r   <= new_fill;
      out_row_end_r <= done;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign out_count   = out_count_r;
  assign out_row_end = out_row_end_r;

  a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    row_pos_r < row_len)
    else $error("row position reached row length");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != 4'd0) && (out_count_r <= 4'd8))
    else $error("emitted byte count out of range");

  a_partial_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit && !done) |-> (new_fill == 4'd8))
    else $error("partial word emitted before row end");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule
